[rtl/frt_pkg.sv]
// Shared types and constants for the fragment reassembly ring tracker.
// Used by the controller, the datapath, the top level and the port checker.
// No dependencies.
package frt_pkg;

   // Field widths of one request and one response transaction
   localparam int HEADER_W = 8;
   localparam int SLOT_OUT_W = 3;
   localparam int COUNT_W = 4;
   localparam int ERROR_W = 3;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   // Header layout
   localparam int SEQ_LSB = 5;
   localparam int SEQ_W = 3;
   localparam int LAST_FRAG_BIT = 4;

   // Frame size limit
   localparam logic [COUNT_W-1:0] MAX_FRAGMENTS = 4'd8;

   // Request kinds carried on tuser
   localparam logic CMD_FRAGMENT = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   // Error codes
   localparam logic [ERROR_W-1:0] ERR_NONE = 3'd0;
   localparam logic [ERROR_W-1:0] ERR_START_MISMATCH = 3'd1;
   localparam logic [ERROR_W-1:0] ERR_UNDERFLOW = 3'd2;
   localparam logic [ERROR_W-1:0] ERR_ZERO_RELEASE = 3'd3;
   localparam logic [ERROR_W-1:0] ERR_OVERFLOW = 3'd4;
   localparam logic [ERROR_W-1:0] ERR_TOO_MANY = 3'd5;

   // Sequencer states
   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } ctrl_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;   // latch the request transaction
      logic execute;   // update ring state and load the response register
   } dp_cmd_type;

endpackage

[rtl/frt_ctrl.sv]
// Sequencer for the ring tracker: request/response handshakes and datapath commands.
// Depends on frt_pkg.
module frt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output frt_pkg::dp_cmd_type cmd
);
   import frt_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic           exec_fire;

   // Response register is free when empty or being drained this cycle
   assign exec_fire = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and commands
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      cmd.capture = (state_ff == ST_IDLE) && req_tvalid;
      cmd.execute = exec_fire;
   end

   // Response valid flag
   always_comb begin
      priority if (exec_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

[rtl/frt_datapath.sv]
// Ring bookkeeping: head, tail, occupancy and fragment count, plus the response register.
// Depends on frt_pkg; driven by commands from frt_ctrl.
module frt_datapath #(
   parameter int RING_DEPTH = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  frt_pkg::dp_cmd_type               cmd,
   input  logic [frt_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                              req_tuser,
   output logic [frt_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tlast
);
   import frt_pkg::*;

   localparam int SLOT_W = $clog2(RING_DEPTH);
   localparam int OCC_W = $clog2(2 * RING_DEPTH);
   localparam int MOD_W = SLOT_W + 5;
   localparam int MOD_STEPS = (RING_DEPTH + 14) / RING_DEPTH;
   localparam int WIDE_W = OCC_W + COUNT_W;
   localparam logic [OCC_W-1:0] OCC_LIMIT = OCC_W'(2 * RING_DEPTH - 1);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RING_DEPTH - 1);

   // Small modulo by the ring depth; input stays below depth + 15
   function automatic logic [SLOT_W-1:0] ring_mod(input logic [MOD_W-1:0] v);
      logic [MOD_W-1:0] r;
      r = v;
      for (int i = 0; i < MOD_STEPS; i++) begin
         if (r >= MOD_W'(RING_DEPTH)) begin
            r = r - MOD_W'(RING_DEPTH);
         end
      end
      return r[SLOT_W-1:0];
   endfunction

   // Ring state
   logic [SLOT_W-1:0]  head_ff, head_in;
   logic [SLOT_W-1:0]  tail_ff, tail_in;
   logic [OCC_W-1:0]   occ_ff, occ_in;
   logic [COUNT_W-1:0] frag_ff, frag_in;

   // Captured request
   logic                kind_ff;
   logic [HEADER_W-1:0] header_ff;
   logic [2:0]          rstart_ff;
   logic [COUNT_W-1:0]  rcount_ff;

   // Response register
   logic [SLOT_OUT_W-1:0] wslot_ff, wslot_in;
   logic                  commit_ff, commit_in;
   logic                  drop_ff, drop_in;
   logic                  ind_ff, ind_in;
   logic [SLOT_OUT_W-1:0] fstart_ff, fstart_in;
   logic [COUNT_W-1:0]    fcount_ff, fcount_in;
   logic [ERROR_W-1:0]    err_ff, err_in;

   // Intermediate terms
   logic [7:0]          head_ext;
   logic [7:0]          tail_ext;
   logic [SEQ_W-1:0]    seq;
   logic [SLOT_W-1:0]   back;
   logic [SLOT_W:0]     tail_sub;
   logic [SLOT_W-1:0]   tail_back;
   logic [SLOT_W-1:0]   tail_inc;
   logic [OCC_W-1:0]    occ_inc;
   logic [COUNT_W-1:0]  frag_inc;
   logic [WIDE_W-1:0]   occ_wide;
   logic [WIDE_W-1:0]   frag_wide;
   logic [WIDE_W-1:0]   rcount_wide;
   logic [SLOT_W-1:0]   head_adv;

   assign head_ext = 8'(head_ff);
   assign tail_ext = 8'(tail_ff);
   assign seq = header_ff[SEQ_LSB +: SEQ_W];

   // Rollback and advance pointer arithmetic
   always_comb begin
      back = ring_mod(MOD_W'(frag_ff));
      tail_sub = {1'b0, tail_ff} + (SLOT_W + 1)'(RING_DEPTH) - {1'b0, back};
      if (tail_sub >= (SLOT_W + 1)'(RING_DEPTH)) begin
         tail_back = tail_sub[SLOT_W-1:0] - SLOT_W'(RING_DEPTH);
      end else begin
         tail_back = tail_sub[SLOT_W-1:0];
      end
      tail_inc = (tail_ff == SLOT_LAST) ? '0 : tail_ff + 1'b1;
      occ_inc = (occ_ff < OCC_LIMIT) ? occ_ff + 1'b1 : occ_ff;
      frag_inc = frag_ff + 1'b1;
      occ_wide = WIDE_W'(occ_ff);
      frag_wide = WIDE_W'(frag_ff);
      rcount_wide = WIDE_W'(rcount_ff);
      head_adv = ring_mod(MOD_W'(head_ff) + MOD_W'(rcount_ff));
   end

   // Next ring state and response
   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      occ_in = occ_ff;
      frag_in = frag_ff;
      wslot_in = '0;
      commit_in = 1'b0;
      drop_in = 1'b0;
      ind_in = 1'b0;
      fstart_in = '0;
      fcount_in = '0;
      err_in = ERR_NONE;
      if (kind_ff == CMD_FRAGMENT) begin
         wslot_in = tail_ext[SLOT_OUT_W-1:0];
         if (frag_ff != COUNT_W'(seq)) begin
            // sequence break: roll back the partial frame when possible
            drop_in = 1'b1;
            if (occ_wide >= frag_wide) begin
               occ_in = occ_ff - OCC_W'(frag_ff);
               tail_in = tail_back;
               frag_in = '0;
            end
         end else begin
            commit_in = 1'b1;
            tail_in = tail_inc;
            occ_in = occ_inc;
            frag_in = frag_inc;
            priority if (WIDE_W'(occ_inc) > WIDE_W'(RING_DEPTH)) begin
               err_in = ERR_OVERFLOW;
            end else if (frag_inc > MAX_FRAGMENTS) begin
               err_in = ERR_TOO_MANY;
            end else begin
               err_in = ERR_NONE;
            end
            if (header_ff[LAST_FRAG_BIT]) begin
               ind_in = 1'b1;
               fstart_in = head_ext[SLOT_OUT_W-1:0];
               fcount_in = frag_inc;
               frag_in = '0;
            end
         end
      end else begin
         // release at head
         if (rcount_ff != '0) begin
            head_in = head_adv;
            if (occ_wide < rcount_wide) begin
               err_in = ERR_UNDERFLOW;
            end else begin
               occ_in = occ_ff - OCC_W'(rcount_ff);
            end
         end else begin
            err_in = ERR_ZERO_RELEASE;
         end
         if (rstart_ff != head_ext[2:0]) begin
            err_in = ERR_START_MISMATCH;
         end
      end
   end

   // Ring state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         occ_ff <= '0;
         frag_ff <= '0;
      end else if (cmd.execute) begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         occ_ff <= occ_in;
         frag_ff <= frag_in;
      end
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_tuser;
         header_ff <= req_tdata[7:0];
         rstart_ff <= req_tdata[10:8];
         rcount_ff <= req_tdata[14:11];
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         wslot_ff <= wslot_in;
         commit_ff <= commit_in;
         drop_ff <= drop_in;
         ind_ff <= ind_in;
         fstart_ff <= fstart_in;
         fcount_ff <= fcount_in;
         err_ff <= err_in;
      end
   end

   assign rsp_tdata = {1'b0, err_ff, fcount_ff, fstart_ff, drop_ff, commit_ff, wslot_ff};
   assign rsp_tlast = ind_ff;

endmodule

[rtl/fragment_reassembly_ring_tracker_core.sv]
// Top level of the fragment reassembly ring tracker.
// Depends on frt_pkg, frt_ctrl and frt_datapath.
//
//   Channel  Dir  Handshake            Payload
//   req      in   req_tvalid/tready    tdata: header, release_start, release_count;
//                                      tuser: command
//   rsp      out  rsp_tvalid/tready    tdata: result fields; tlast: indicate
//
// Each request is captured in the idle state, then an execute step updates
// head, tail and counts and loads the response register.
// The execute step waits while a previous response is still held by a stalled
// consumer; the next request is taken as soon as execute completes.
// Reset is synchronous and clears pointers, counts and the response valid flag.
module fragment_reassembly_ring_tracker_core #(
   parameter int RING_DEPTH = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [7:0] header, [10:8] release_start, [14:11] release_count, [15] zero
   input  logic [frt_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] command
   input  logic                           req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [2:0] write_slot, [3] committed, [4] dropped, [7:5] frame_start,
   // [11:8] frame_count, [14:12] error_code, [15] zero
   output logic [frt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast
);
   import frt_pkg::*;

   dp_cmd_type cmd;

   // Sequencer
   frt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // Ring bookkeeping
   frt_datapath #(
      .RING_DEPTH (RING_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

endmodule

[rtl/frt_checker.sv]
// Port-level checks for the fragment reassembly ring tracker, bound to the top level.
// Depends on frt_pkg and fragment_reassembly_ring_tracker_core.
module frt_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [frt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tlast
);
   import frt_pkg::*;

   // A stalled response transaction holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   // One request in flight: ready drops right after an accepted transaction
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while another is in progress");

   // A fragment is never both kept and dropped
   a_commit_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[3] && rsp_tdata[4]))
      else $error("committed and dropped both set");

   // An indication only comes with a committed fragment
   a_indicate: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[3])
      else $error("indication without commit");

   // A dropped fragment reports no error
   a_drop_err: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[4] |-> rsp_tdata[14:12] == ERR_NONE)
      else $error("dropped fragment carries an error code");

endmodule

bind fragment_reassembly_ring_tracker_core frt_checker u_frt_checker (.*);

[tb/sv/testbench.sv]
// Self-checking testbench for fragment_reassembly_ring_tracker_core.
// Drives fragment and release transactions, predicts each response from a ring model.
// Depends on frt_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;
   import frt_pkg::*;

   localparam int RING_SLOTS = 8;
   localparam logic [COUNT_W-1:0] OCC_CEILING = 4'd15;   // 2 * ring depth - 1
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_EVENTS = 1450;
   localparam int BACKPRESSURE_AT = 300;    // responses seen before the long hold
   localparam int BACKPRESSURE_LEN = 80;
   localparam int CALM_FIRST = 700;          // request window with no idling
   localparam int CALM_LAST = 1000;

   // One request transaction
   typedef struct packed {
      logic                  drain;   // sender waits for all responses first
      logic                  command;
      logic [HEADER_W-1:0]   header;
      logic [2:0]            rel_start;
      logic [COUNT_W-1:0]    rel_count;
   } ring_event_type;

   // One response transaction
   typedef struct packed {
      logic [SLOT_OUT_W-1:0] write_slot;
      logic                  committed;
      logic                  dropped;
      logic                  indicate;
      logic [SLOT_OUT_W-1:0] frame_start;
      logic [COUNT_W-1:0]    frame_count;
      logic [ERROR_W-1:0]    error_code;
   } ring_result_type;

   typedef struct packed {
      logic [2:0]         head;
      logic [2:0]         tail;
      logic [COUNT_W-1:0] occupied;
      logic [COUNT_W-1:0] frags;
   } ring_state_type;

   typedef struct packed {
      ring_state_type  st;
      ring_result_type res;
   } ring_outcome_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   ring_event_type  pending_events[$];
   ring_result_type expected_results[$];
   ring_event_type  cur_event;
   ring_state_type  tracked_state = '0;   // follows accepted requests
   ring_state_type  gen_state = '0;       // follows generated requests
   int              requests_done = 0;
   int              responses_done = 0;
   int              error_count = 0;
   int              quiet_cycles = 0;
   int              hold_cycles = 0;
   bit              hold_done = 1'b0;
   bit              drain_next = 1'b0;

   wire calm = (requests_done >= CALM_FIRST) && (requests_done < CALM_LAST);

   fragment_reassembly_ring_tracker_core #(.RING_DEPTH(RING_SLOTS)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Ring bookkeeping for one event: returns next state and the response
   function automatic ring_outcome_type track_event(ring_state_type st, ring_event_type ev);
      ring_outcome_type o;
      logic             start_bad;
      o.res = '0;
      if (ev.command == CMD_FRAGMENT) begin
         o.res.write_slot = st.tail;
         if ({1'b0, ev.header[SEQ_LSB +: SEQ_W]} != st.frags) begin
            o.res.dropped = 1'b1;
            // roll back the partial frame only if enough slots are held
            if (st.occupied >= st.frags) begin
               st.occupied = st.occupied - st.frags;
               st.tail = st.tail - st.frags[2:0];
               st.frags = '0;
            end
         end else begin
            o.res.committed = 1'b1;
            st.tail = st.tail + 3'd1;
            if (st.occupied < OCC_CEILING)
               st.occupied = st.occupied + 1'b1;
            st.frags = st.frags + 1'b1;
            if (st.occupied > RING_SLOTS)
               o.res.error_code = ERR_OVERFLOW;
            else if (st.frags > MAX_FRAGMENTS)
               o.res.error_code = ERR_TOO_MANY;
            if (ev.header[LAST_FRAG_BIT]) begin
               o.res.indicate = 1'b1;
               o.res.frame_start = st.head;
               o.res.frame_count = st.frags;
               st.frags = '0;
            end
         end
      end else begin
         start_bad = (ev.rel_start != st.head);
         if (ev.rel_count != 0) begin
            st.head = st.head + ev.rel_count[2:0];
            if (st.occupied < ev.rel_count)
               o.res.error_code = ERR_UNDERFLOW;
            else
               st.occupied = st.occupied - ev.rel_count;
         end else begin
            o.res.error_code = ERR_ZERO_RELEASE;
         end
         if (start_bad)
            o.res.error_code = ERR_START_MISMATCH;
      end
      o.st = st;
      return o;
   endfunction

   task automatic queue_event(ring_event_type ev);
      ring_outcome_type o;
      ev.drain = drain_next;
      drain_next = 1'b0;
      o = track_event(gen_state, ev);
      gen_state = o.st;
      pending_events.push_back(ev);
   endtask

   // Unused fields carry random filler
   task automatic queue_fragment(logic [HEADER_W-1:0] header);
      ring_event_type ev;
      ev.drain = 1'b0;
      ev.command = CMD_FRAGMENT;
      ev.header = header;
      ev.rel_start = 3'($urandom);
      ev.rel_count = 4'($urandom_range(8));
      queue_event(ev);
   endtask

   task automatic queue_release(logic [2:0] start, logic [COUNT_W-1:0] count);
      ring_event_type ev;
      ev.drain = 1'b0;
      ev.command = CMD_RELEASE;
      ev.header = 8'($urandom);
      ev.rel_start = start;
      ev.rel_count = count;
      queue_event(ev);
   endtask

   task automatic queue_frame(int unsigned n_frags, bit inject_error);
      int unsigned bad_at;
      logic [2:0]  seq;
      bad_at = $urandom_range(n_frags - 1);
      for (int unsigned i = 0; i < n_frags; i++) begin
         seq = gen_state.frags[2:0];
         if (inject_error && i == bad_at) begin
            queue_fragment({3'(seq + $urandom_range(1, 7)), 1'($urandom), 4'($urandom)});
            break;
         end
         queue_fragment({seq, i == n_frags - 1, 4'($urandom)});
      end
   endtask

   // Stimulus: directed cases first, then random traffic
   initial begin
      int unsigned pick;
      int unsigned most;
      bit          mid_drain_set;
      mid_drain_set = 1'b0;

      // single-fragment frame, then a three-fragment frame
      queue_fragment(8'h10);
      queue_fragment(8'h00);
      queue_fragment(8'h20);
      queue_fragment(8'h5F);
      // mismatch with no partial frame
      queue_fragment(8'h60);
      // partial frame of two, then rollback on a bad sequence
      queue_fragment(8'h00);
      queue_fragment(8'h2A);
      queue_fragment(8'hFF);
      // releases: clean, zero, mismatch over underflow, underflow, mismatch over zero
      queue_release(gen_state.head, gen_state.occupied);
      queue_release(gen_state.head, 4'd0);
      queue_release(gen_state.head ^ 3'd5, 4'd8);
      queue_release(gen_state.head, 4'd2);
      queue_release(gen_state.head ^ 3'd3, 4'd0);
      // rollback short of slots: partial frame freed underneath, then mismatch
      queue_fragment(8'h00);
      queue_fragment(8'h20);
      queue_release(gen_state.head, 4'd2);
      queue_fragment(8'hA0);
      queue_fragment(8'h50);
      // full eight-fragment frame runs the ring past its depth
      queue_frame(8, 1'b0);
      queue_release(gen_state.head, 4'd8);
      queue_fragment(8'h80);

      // first random transaction waits for the directed part to drain
      drain_next = 1'b1;
      for (int n = 0; n < RANDOM_EVENTS; ) begin
         if (!mid_drain_set && n >= RANDOM_EVENTS / 2) begin
            drain_next = 1'b1;
            mid_drain_set = 1'b1;
         end
         pick = $urandom_range(99);
         if (pick < 55) begin
            most = ($urandom_range(99) < 80) ? $urandom_range(1, 3) : $urandom_range(4, 8);
            queue_frame(most, $urandom_range(99) < 10);
            n += most;
         end else if (pick < 80) begin
            if (gen_state.occupied == 0)
               queue_release(gen_state.head, 4'($urandom_range(8)));
            else begin
               most = (gen_state.occupied > 8) ? 8 : gen_state.occupied;
               queue_release(gen_state.head, 4'($urandom_range(1, most)));
            end
            n++;
         end else begin
            if ($urandom_range(1))
               queue_fragment(8'($urandom));
            else
               queue_release(3'($urandom), 4'($urandom_range(8)));
            n++;
         end
      end
   end

   // Reset and end of run
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (pending_events.size() > 0 || req_tvalid || expected_results.size() > 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // Request driver
   always @(posedge clock) begin
      ring_outcome_type o;
      logic             offer;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         offer = req_tvalid;
         if (req_tvalid && req_tready) begin
            o = track_event(tracked_state, cur_event);
            tracked_state = o.st;
            expected_results.push_back(o.res);
            requests_done++;
            offer = 1'b0;
         end
         if (!offer && pending_events.size() > 0 && (calm || $urandom_range(99) >= 26) &&
             !(pending_events[0].drain && expected_results.size() != 0)) begin
            cur_event = pending_events.pop_front();
            req_tdata <= {1'b0, cur_event.rel_count, cur_event.rel_start, cur_event.header};
            req_tuser <= cur_event.command;
            offer = 1'b1;
         end
         req_tvalid <= offer;
      end
   end

   task automatic compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // Response monitor and receiver backpressure
   always @(posedge clock) begin
      ring_result_type want;
      logic            take;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("response transaction with no request outstanding");
               error_count++;
            end else begin
               want = expected_results.pop_front();
               compare_field("write_slot", want.write_slot, rsp_tdata[2:0]);
               compare_field("committed", want.committed, rsp_tdata[3]);
               compare_field("dropped", want.dropped, rsp_tdata[4]);
               compare_field("indicate", want.indicate, rsp_tlast);
               compare_field("frame_start", want.frame_start, rsp_tdata[7:5]);
               compare_field("frame_count", want.frame_count, rsp_tdata[11:8]);
               compare_field("error_code", want.error_code, rsp_tdata[14:12]);
            end
            responses_done++;
         end
         // one long hold so the core fills up and stalls its input
         if (hold_cycles > 0) begin
            hold_cycles--;
            take = 1'b0;
         end else if (!hold_done && responses_done >= BACKPRESSURE_AT) begin
            hold_done = 1'b1;
            hold_cycles = BACKPRESSURE_LEN;
            take = 1'b0;
         end else begin
            take = calm || ($urandom_range(99) >= 26);
         end
         rsp_tready <= take;
      end
   end

   // Watchdog on cycles with no transaction on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

[filelist.f]
rtl/frt_pkg.sv
rtl/frt_ctrl.sv
rtl/frt_datapath.sv
rtl/fragment_reassembly_ring_tracker_core.sv
rtl/frt_checker.sv
tb/sv/testbench.sv
